// ----- rtl/lfba_pkg.sv -----
// Package: shared types and constants of the largest free block allocator.
`default_nettype none
package lfba_pkg;

  localparam int CELL_W = 21;
  localparam int ID_W   = 10;
  localparam int CFG_W  = 32;

  typedef struct packed {
    logic              free;
    logic [CELL_W-1:0] start;
    logic [CELL_W-1:0] size;
  } sec_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE,
    S_A_CHECK, S_A_RDH, S_A_RDS, S_A_CMP, S_A_DECIDE, S_A_FAIL,
    S_A_POP, S_A_SPL1, S_A_SPL2, S_A_RDLAST, S_A_NOSPL, S_A_DONE,
    S_F_OWN, S_F_OWNQ, S_F_SECQ, S_F_PCHK,
    S_R_RDH, S_R_CMP, S_R_RDL, S_R_WR,
    S_F_PUNL, S_F_RDN, S_F_NRD, S_F_NCHK, S_F_NUNL, S_F_FIN
  } st_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_INIT, OP_LOAD, OP_A_START, OP_RD_HEAP, OP_RD_SEC_H, OP_A_CMP,
    OP_OUT_FAIL, OP_OUT_OK, OP_POP, OP_SPL1, OP_SPL2, OP_RD_LAST, OP_NOSPL,
    OP_RD_OWN, OP_F_CLR, OP_F_LOADS, OP_F_PMERGE, OP_INC, OP_R_WR, OP_PUNL,
    OP_RD_NEXT, OP_F_NRD, OP_F_NMERGE, OP_NUNL, OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   in_ready;
  } cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic in_valid;
    logic in_op;
    logic init_last;
    logic bad_req;
    logic id_oor;
    logic idx_end;
    logic dec_fail;
    logic dec_split;
    logic hit;
    logic own_valid;
    logic sec_free;
    logic nb_none;
    logic out_busy;
    logic ret_next;
  } stat_t;

endpackage
`default_nettype wire

// ----- rtl/lfba_ctrl.sv -----
// Controller: sequences allocate, free and clearing steps of the datapath.
`default_nettype none
module lfba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire lfba_pkg::stat_t st,
  output lfba_pkg::cmd_t     cmd
);

  lfba_pkg::st_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfba_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lfba_pkg::S_INIT:     if (st.init_last) state_next = lfba_pkg::S_IDLE;
      lfba_pkg::S_IDLE: begin
        if (st.in_valid) begin
          state_next = st.in_op ? lfba_pkg::S_F_OWN : lfba_pkg::S_A_CHECK;
        end
      end
      lfba_pkg::S_A_CHECK:
        state_next = st.bad_req ? lfba_pkg::S_A_FAIL : lfba_pkg::S_A_RDH;
      lfba_pkg::S_A_RDH:
        state_next = st.idx_end ? lfba_pkg::S_A_DECIDE : lfba_pkg::S_A_RDS;
      lfba_pkg::S_A_RDS:    state_next = lfba_pkg::S_A_CMP;
      lfba_pkg::S_A_CMP:    state_next = lfba_pkg::S_A_RDH;
      lfba_pkg::S_A_DECIDE: begin
        if (st.dec_fail) state_next = lfba_pkg::S_A_FAIL;
        else if (st.dec_split) state_next = lfba_pkg::S_A_POP;
        else state_next = lfba_pkg::S_A_RDLAST;
      end
      lfba_pkg::S_A_FAIL:   if (!st.out_busy) state_next = lfba_pkg::S_IDLE;
      lfba_pkg::S_A_POP:    state_next = lfba_pkg::S_A_SPL1;
      lfba_pkg::S_A_SPL1:   state_next = lfba_pkg::S_A_SPL2;
      lfba_pkg::S_A_SPL2:   state_next = lfba_pkg::S_A_DONE;
      lfba_pkg::S_A_RDLAST: state_next = lfba_pkg::S_A_NOSPL;
      lfba_pkg::S_A_NOSPL:  state_next = lfba_pkg::S_A_DONE;
      lfba_pkg::S_A_DONE:   if (!st.out_busy) state_next = lfba_pkg::S_IDLE;
      lfba_pkg::S_F_OWN:
        state_next = st.id_oor ? lfba_pkg::S_IDLE : lfba_pkg::S_F_OWNQ;
      lfba_pkg::S_F_OWNQ:
        state_next = st.own_valid ? lfba_pkg::S_F_SECQ : lfba_pkg::S_IDLE;
      lfba_pkg::S_F_SECQ:
        state_next = st.sec_free ? lfba_pkg::S_IDLE : lfba_pkg::S_F_PCHK;
      lfba_pkg::S_F_PCHK: begin
        if (st.nb_none || !st.sec_free) state_next = lfba_pkg::S_F_RDN;
        else state_next = lfba_pkg::S_R_RDH;
      end
      lfba_pkg::S_R_RDH: begin
        if (!st.idx_end) state_next = lfba_pkg::S_R_CMP;
        else state_next = st.ret_next ? lfba_pkg::S_F_NUNL : lfba_pkg::S_F_PUNL;
      end
      lfba_pkg::S_R_CMP:
        state_next = st.hit ? lfba_pkg::S_R_RDL : lfba_pkg::S_R_RDH;
      lfba_pkg::S_R_RDL:    state_next = lfba_pkg::S_R_WR;
      lfba_pkg::S_R_WR:
        state_next = st.ret_next ? lfba_pkg::S_F_NUNL : lfba_pkg::S_F_PUNL;
      lfba_pkg::S_F_PUNL:   state_next = lfba_pkg::S_F_RDN;
      lfba_pkg::S_F_RDN:    state_next = lfba_pkg::S_F_NRD;
      lfba_pkg::S_F_NRD:    state_next = lfba_pkg::S_F_NCHK;
      lfba_pkg::S_F_NCHK: begin
        if (st.nb_none || !st.sec_free) state_next = lfba_pkg::S_F_FIN;
        else state_next = lfba_pkg::S_R_RDH;
      end
      lfba_pkg::S_F_NUNL:   state_next = lfba_pkg::S_F_FIN;
      lfba_pkg::S_F_FIN:    state_next = lfba_pkg::S_IDLE;
      default:              state_next = lfba_pkg::S_INIT;
    endcase
    if (st.cfg_wr) state_next = lfba_pkg::S_INIT;
  end

  always_comb begin
    cmd.in_ready = 1'b0;
    cmd.op       = lfba_pkg::OP_NOP;
    case (state)
      lfba_pkg::S_INIT:     cmd.op = lfba_pkg::OP_INIT;
      lfba_pkg::S_IDLE: begin
        cmd.in_ready = !st.cfg_wr;
        if (st.in_valid && !st.cfg_wr) cmd.op = lfba_pkg::OP_LOAD;
      end
      lfba_pkg::S_A_CHECK:  cmd.op = lfba_pkg::OP_A_START;
      lfba_pkg::S_A_RDH:    if (!st.idx_end) cmd.op = lfba_pkg::OP_RD_HEAP;
      lfba_pkg::S_A_RDS:    cmd.op = lfba_pkg::OP_RD_SEC_H;
      lfba_pkg::S_A_CMP:    cmd.op = lfba_pkg::OP_A_CMP;
      lfba_pkg::S_A_DECIDE: cmd.op = lfba_pkg::OP_NOP;
      lfba_pkg::S_A_FAIL:   if (!st.out_busy) cmd.op = lfba_pkg::OP_OUT_FAIL;
      lfba_pkg::S_A_POP:    cmd.op = lfba_pkg::OP_POP;
      lfba_pkg::S_A_SPL1:   cmd.op = lfba_pkg::OP_SPL1;
      lfba_pkg::S_A_SPL2:   cmd.op = lfba_pkg::OP_SPL2;
      lfba_pkg::S_A_RDLAST: cmd.op = lfba_pkg::OP_RD_LAST;
      lfba_pkg::S_A_NOSPL:  cmd.op = lfba_pkg::OP_NOSPL;
      lfba_pkg::S_A_DONE:   if (!st.out_busy) cmd.op = lfba_pkg::OP_OUT_OK;
      lfba_pkg::S_F_OWN:    if (!st.id_oor) cmd.op = lfba_pkg::OP_RD_OWN;
      lfba_pkg::S_F_OWNQ:   if (st.own_valid) cmd.op = lfba_pkg::OP_F_CLR;
      lfba_pkg::S_F_SECQ:   if (!st.sec_free) cmd.op = lfba_pkg::OP_F_LOADS;
      lfba_pkg::S_F_PCHK:
        if (!st.nb_none && st.sec_free) cmd.op = lfba_pkg::OP_F_PMERGE;
      lfba_pkg::S_R_RDH:    if (!st.idx_end) cmd.op = lfba_pkg::OP_RD_HEAP;
      lfba_pkg::S_R_CMP:    if (!st.hit) cmd.op = lfba_pkg::OP_INC;
      lfba_pkg::S_R_RDL:    cmd.op = lfba_pkg::OP_RD_LAST;
      lfba_pkg::S_R_WR:     cmd.op = lfba_pkg::OP_R_WR;
      lfba_pkg::S_F_PUNL:   cmd.op = lfba_pkg::OP_PUNL;
      lfba_pkg::S_F_RDN:    cmd.op = lfba_pkg::OP_RD_NEXT;
      lfba_pkg::S_F_NRD:    cmd.op = lfba_pkg::OP_F_NRD;
      lfba_pkg::S_F_NCHK:
        if (!st.nb_none && st.sec_free) cmd.op = lfba_pkg::OP_F_NMERGE;
      lfba_pkg::S_F_NUNL:   cmd.op = lfba_pkg::OP_NUNL;
      lfba_pkg::S_F_FIN:    cmd.op = lfba_pkg::OP_FIN;
      default:              cmd.op = lfba_pkg::OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/lfba_dp.sv -----
// Datapath: section, link, free list, spare stack and owner memories.
`default_nettype none
module lfba_dp #(
  parameter int MAX_SECTIONS = 256,
  parameter int MAX_IDS      = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lfba_pkg::cmd_t              cmd,
  output lfba_pkg::stat_t                  st,
  input  wire logic                        cfg_wr,
  input  wire logic [lfba_pkg::CELL_W-1:0] cfg_data,
  output logic      [lfba_pkg::CELL_W-1:0] total,
  input  wire logic                        in_valid,
  input  wire logic                        operation,
  input  wire logic [lfba_pkg::ID_W-1:0]   request_id,
  input  wire logic [lfba_pkg::CELL_W-1:0] request_size,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             granted,
  output logic      [lfba_pkg::CELL_W-1:0] start_cell
);

  localparam int SW     = $clog2(MAX_SECTIONS);
  localparam int LW     = SW + 1;
  localparam int CW     = $clog2(MAX_SECTIONS + 1);
  localparam int IDW    = $clog2(MAX_IDS);
  localparam int INIT_N = (MAX_IDS > MAX_SECTIONS) ? MAX_IDS : MAX_SECTIONS;
  localparam int KW     = $clog2(INIT_N);
  localparam int CELL_W = lfba_pkg::CELL_W;
  localparam logic [LW-1:0] NO_LINK = {1'b1, {SW{1'b0}}};

  lfba_pkg::sec_t sec_mem [MAX_SECTIONS];
  logic [LW-1:0]  prev_mem [MAX_SECTIONS];
  logic [LW-1:0]  next_mem [MAX_SECTIONS];
  logic [SW-1:0]  heap_mem [MAX_SECTIONS];
  logic [SW-1:0]  stack_mem [MAX_SECTIONS];
  logic [SW:0]    own_mem [MAX_IDS];

  lfba_pkg::sec_t sec_q;
  logic [LW-1:0]  prev_q, next_q;
  logic [SW-1:0]  heap_q, stack_q;
  logic [SW:0]    own_q;

  logic [lfba_pkg::ID_W-1:0] req_id;
  logic [CELL_W-1:0] req_size;
  logic [SW-1:0]     cur_slot, best_slot, best_pos, spare_slot, tgt;
  logic [CELL_W-1:0] cur_start, cur_size, best_start, best_size;
  logic              best_any, ret_next;
  logic [LW-1:0]     nb;
  logic [CW-1:0]     idx, cnt, spare_cnt;
  logic [KW-1:0]     k;

  logic              sec_re, prev_re, next_re, heap_re, stack_re, own_re;
  logic [SW-1:0]     sec_ra, prev_ra, next_ra, heap_ra, stack_ra;
  logic [IDW-1:0]    own_ra;
  logic              sec_we, prev_we, next_we, heap_we, stack_we, own_we;
  logic [SW-1:0]     sec_wa, prev_wa, next_wa, heap_wa, stack_wa;
  logic [IDW-1:0]    own_wa;
  lfba_pkg::sec_t    sec_wd;
  logic [LW-1:0]     prev_wd, next_wd;
  logic [SW-1:0]     heap_wd, stack_wd;
  logic [SW:0]       own_wd;

  logic [CW-1:0]     heap_last;
  logic              better, split, k_first, cnt_room;

  assign heap_last = cnt - CW'(1);
  assign k_first   = (k == '0);
  assign cnt_room  = 32'(cnt) < 32'(MAX_SECTIONS);
  assign split     = best_size != req_size;
  assign better    = !best_any || (sec_q.size > best_size) ||
                     ((sec_q.size == best_size) && (sec_q.start > best_start));

  always_comb begin
    st.cfg_wr    = cfg_wr;
    st.in_valid  = in_valid;
    st.in_op     = operation;
    st.init_last = 32'(k) == INIT_N - 1;
    st.id_oor    = 32'(req_id) >= 32'(MAX_IDS);
    st.bad_req   = (req_size == '0) || st.id_oor;
    st.idx_end   = idx == cnt;
    st.dec_split = split;
    st.dec_fail  = !best_any || (best_size < req_size) || (split && spare_cnt == '0);
    st.hit       = heap_q == tgt;
    st.own_valid = own_q[SW];
    st.sec_free  = sec_q.free;
    st.nb_none   = nb[SW];
    st.out_busy  = out_valid && !out_ready;
    st.ret_next  = ret_next;
  end

  always_comb begin
    sec_re = 1'b0; prev_re = 1'b0; next_re = 1'b0;
    heap_re = 1'b0; stack_re = 1'b0; own_re = 1'b0;
    sec_ra = '0; prev_ra = '0; next_ra = '0; heap_ra = '0; stack_ra = '0; own_ra = '0;
    sec_we = 1'b0; prev_we = 1'b0; next_we = 1'b0;
    heap_we = 1'b0; stack_we = 1'b0; own_we = 1'b0;
    sec_wa = '0; prev_wa = '0; next_wa = '0; heap_wa = '0; stack_wa = '0; own_wa = '0;
    sec_wd = '0; prev_wd = NO_LINK; next_wd = NO_LINK;
    heap_wd = '0; stack_wd = '0; own_wd = '0;
    case (cmd.op)
      lfba_pkg::OP_INIT: begin
        sec_we   = k_first;
        sec_wd   = '{free: 1'b1, start: CELL_W'(1), size: total};
        prev_we  = k_first;
        next_we  = k_first;
        heap_we  = k_first;
        stack_we = 32'(k) < MAX_SECTIONS - 1;
        stack_wa = SW'(k);
        stack_wd = SW'(32'(k) + 1);
        own_we   = 32'(k) < MAX_IDS;
        own_wa   = IDW'(k);
      end
      lfba_pkg::OP_RD_HEAP: begin
        heap_re = 1'b1;
        heap_ra = idx[SW-1:0];
      end
      lfba_pkg::OP_RD_LAST: begin
        heap_re = 1'b1;
        heap_ra = heap_last[SW-1:0];
      end
      lfba_pkg::OP_RD_SEC_H: begin
        sec_re = 1'b1;
        sec_ra = heap_q;
      end
      lfba_pkg::OP_POP: begin
        stack_re = 1'b1;
        stack_ra = SW'(spare_cnt - CW'(1));
        next_re  = 1'b1;
        next_ra  = best_slot;
      end
      lfba_pkg::OP_SPL1: begin
        sec_we  = 1'b1;
        sec_wa  = stack_q;
        sec_wd  = '{free: 1'b1, start: best_start + req_size, size: best_size - req_size};
        prev_we = 1'b1;
        prev_wa = stack_q;
        prev_wd = {1'b0, best_slot};
        next_we = 1'b1;
        next_wa = stack_q;
        next_wd = next_q;
        heap_we = 1'b1;
        heap_wa = best_pos;
        heap_wd = stack_q;
      end
      lfba_pkg::OP_SPL2: begin
        next_we = 1'b1;
        next_wa = best_slot;
        next_wd = {1'b0, spare_slot};
        prev_we = !nb[SW];
        prev_wa = nb[SW-1:0];
        prev_wd = {1'b0, spare_slot};
        sec_we  = 1'b1;
        sec_wa  = best_slot;
        sec_wd  = '{free: 1'b0, start: best_start, size: req_size};
        own_we  = 1'b1;
        own_wa  = IDW'(req_id);
        own_wd  = {1'b1, best_slot};
      end
      lfba_pkg::OP_NOSPL: begin
        heap_we = 1'b1;
        heap_wa = best_pos;
        heap_wd = heap_q;
        sec_we  = 1'b1;
        sec_wa  = best_slot;
        sec_wd  = '{free: 1'b0, start: best_start, size: best_size};
        own_we  = 1'b1;
        own_wa  = IDW'(req_id);
        own_wd  = {1'b1, best_slot};
      end
      lfba_pkg::OP_RD_OWN: begin
        own_re = 1'b1;
        own_ra = IDW'(req_id);
      end
      lfba_pkg::OP_F_CLR: begin
        own_we  = 1'b1;
        own_wa  = IDW'(req_id);
        sec_re  = 1'b1;
        sec_ra  = own_q[SW-1:0];
        prev_re = 1'b1;
        prev_ra = own_q[SW-1:0];
      end
      lfba_pkg::OP_F_LOADS: begin
        sec_re = 1'b1;
        sec_ra = prev_q[SW-1:0];
      end
      lfba_pkg::OP_F_PMERGE: begin
        prev_re = 1'b1;
        prev_ra = nb[SW-1:0];
      end
      lfba_pkg::OP_R_WR: begin
        heap_we = 1'b1;
        heap_wa = idx[SW-1:0];
        heap_wd = heap_q;
      end
      lfba_pkg::OP_PUNL: begin
        prev_we  = 1'b1;
        prev_wa  = cur_slot;
        prev_wd  = prev_q;
        next_we  = !prev_q[SW];
        next_wa  = prev_q[SW-1:0];
        next_wd  = {1'b0, cur_slot};
        stack_we = 1'b1;
        stack_wa = spare_cnt[SW-1:0];
        stack_wd = tgt;
      end
      lfba_pkg::OP_RD_NEXT: begin
        next_re = 1'b1;
        next_ra = cur_slot;
      end
      lfba_pkg::OP_F_NRD: begin
        sec_re = 1'b1;
        sec_ra = next_q[SW-1:0];
      end
      lfba_pkg::OP_F_NMERGE: begin
        next_re = 1'b1;
        next_ra = nb[SW-1:0];
      end
      lfba_pkg::OP_NUNL: begin
        next_we  = 1'b1;
        next_wa  = cur_slot;
        next_wd  = next_q;
        prev_we  = !next_q[SW];
        prev_wa  = next_q[SW-1:0];
        prev_wd  = {1'b0, cur_slot};
        stack_we = 1'b1;
        stack_wa = spare_cnt[SW-1:0];
        stack_wd = tgt;
      end
      lfba_pkg::OP_FIN: begin
        sec_we  = 1'b1;
        sec_wa  = cur_slot;
        sec_wd  = '{free: 1'b1, start: cur_start, size: cur_size};
        heap_we = cnt_room;
        heap_wa = cnt[SW-1:0];
        heap_wd = cur_slot;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (sec_we) sec_mem[sec_wa] <= sec_wd;
    if (sec_re) sec_q <= sec_mem[sec_ra];
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (prev_re) prev_q <= prev_mem[prev_ra];
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next_re) next_q <= next_mem[next_ra];
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    if (heap_re) heap_q <= heap_mem[heap_ra];
    if (stack_we) stack_mem[stack_wa] <= stack_wd;
    if (stack_re) stack_q <= stack_mem[stack_ra];
    if (own_we) own_mem[own_wa] <= own_wd;
    if (own_re) own_q <= own_mem[own_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= CELL_W'(1048576);
      k         <= '0;
      cnt       <= CW'(1);
      spare_cnt <= CW'(MAX_SECTIONS - 1);
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        total <= cfg_data;
        k     <= '0;
      end else if (cmd.op == lfba_pkg::OP_INIT) begin
        k <= k + KW'(1);
      end
      if (cmd.op == lfba_pkg::OP_OUT_FAIL || cmd.op == lfba_pkg::OP_OUT_OK) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        lfba_pkg::OP_INIT: begin
          cnt       <= CW'(1);
          spare_cnt <= CW'(MAX_SECTIONS - 1);
        end
        lfba_pkg::OP_LOAD: begin
          req_id   <= request_id;
          req_size <= request_size;
        end
        lfba_pkg::OP_A_START: begin
          idx      <= '0;
          best_any <= 1'b0;
        end
        lfba_pkg::OP_RD_SEC_H: cur_slot <= heap_q;
        lfba_pkg::OP_A_CMP: begin
          if (better) begin
            best_any   <= 1'b1;
            best_slot  <= cur_slot;
            best_pos   <= idx[SW-1:0];
            best_start <= sec_q.start;
            best_size  <= sec_q.size;
          end
          idx <= idx + CW'(1);
        end
        lfba_pkg::OP_OUT_FAIL: begin
          granted    <= 1'b0;
          start_cell <= '0;
        end
        lfba_pkg::OP_OUT_OK: begin
          granted    <= 1'b1;
          start_cell <= best_start;
        end
        lfba_pkg::OP_SPL1: begin
          spare_slot <= stack_q;
          nb         <= next_q;
          spare_cnt  <= spare_cnt - CW'(1);
        end
        lfba_pkg::OP_NOSPL: cnt <= cnt - CW'(1);
        lfba_pkg::OP_F_CLR: cur_slot <= own_q[SW-1:0];
        lfba_pkg::OP_F_LOADS: begin
          cur_start <= sec_q.start;
          cur_size  <= sec_q.size;
          nb        <= prev_q;
        end
        lfba_pkg::OP_F_PMERGE: begin
          cur_start <= sec_q.start;
          cur_size  <= cur_size + sec_q.size;
          tgt       <= nb[SW-1:0];
          idx       <= '0;
          ret_next  <= 1'b0;
        end
        lfba_pkg::OP_INC: idx <= idx + CW'(1);
        lfba_pkg::OP_R_WR: cnt <= cnt - CW'(1);
        lfba_pkg::OP_PUNL: spare_cnt <= spare_cnt + CW'(1);
        lfba_pkg::OP_F_NRD: nb <= next_q;
        lfba_pkg::OP_F_NMERGE: begin
          cur_size <= cur_size + sec_q.size;
          tgt      <= nb[SW-1:0];
          idx      <= '0;
          ret_next <= 1'b1;
        end
        lfba_pkg::OP_NUNL: spare_cnt <= spare_cnt + CW'(1);
        lfba_pkg::OP_FIN: if (cnt_room) cnt <= cnt + CW'(1);
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/largest_free_block_allocator_core.sv -----
// Top level: APB register port, controller and datapath of the allocator.
// Allocate: a serial scan of the free list over all free sections picks the block.
// Free: a serial free list search for each merged neighbour.
// One item in work at a time; a result waits in the output register meanwhile.
// Reset and a total_cells write run a clearing pass over max(MAX_IDS, MAX_SECTIONS)
// entries with in_ready low.
`default_nettype none
module largest_free_block_allocator_core #(
  parameter int MAX_SECTIONS = 256,
  parameter int MAX_IDS      = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [lfba_pkg::CFG_W-1:0]  pwdata,
  output logic      [lfba_pkg::CFG_W-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        operation,
  input  wire logic [lfba_pkg::ID_W-1:0]   request_id,
  input  wire logic [lfba_pkg::CELL_W-1:0] request_size,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             granted,
  output logic      [lfba_pkg::CELL_W-1:0] start_cell
);

  lfba_pkg::cmd_t  cmd;
  lfba_pkg::stat_t st;
  logic            cfg_wr;
  logic [lfba_pkg::CELL_W-1:0] total;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata   = (paddr[2] == 1'b0) ? lfba_pkg::CFG_W'(total) : '0;
  assign in_ready = cmd.in_ready;

  lfba_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  lfba_dp #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .MAX_IDS      (MAX_IDS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg_wr       (cfg_wr),
    .cfg_data     (pwdata[lfba_pkg::CELL_W-1:0]),
    .total        (total),
    .in_valid     (in_valid),
    .operation    (operation),
    .request_id   (request_id),
    .request_size (request_size),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .granted      (granted),
    .start_cell   (start_cell)
  );

endmodule
`default_nettype wire

// ----- rtl/lfba_chk.sv -----
// Checker: port-level properties of the allocator, bound to the top level.
`default_nettype none
module lfba_chk (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pwrite,
  input wire logic [2:0]                  paddr,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        granted,
  input wire logic [lfba_pkg::CELL_W-1:0] start_cell
);

  a_rst_busy: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("in_ready high right after reset");

  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && !paddr[2]) |=> !in_ready)
    else $error("in_ready high right after config write");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (start_cell == '0))
    else $error("failed item carries a start cell");

  a_grant_nz: assert property (@(posedge clk) disable iff (rst)
    (out_valid && granted) |-> (start_cell != '0))
    else $error("granted item has start cell zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(granted) && $stable(start_cell)))
    else $error("stalled result changed");

endmodule

bind largest_free_block_allocator_core lfba_chk u_lfba_chk (.*);
`default_nettype wire
